@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/core/ffha_pkg.sv @@
package ffha_pkg;

    localparam int CMD_ALLOC = 0;
    localparam int CMD_FREE  = 1;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_NO_FIT  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic        cmd;
        logic [15:0] request_bytes;
        logic        has_block;
        logic [15:0] block_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] payload_offset;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LEN_RD,
        S_LEN_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PREV_RD,
        S_PREV_CHK,
        S_APPLY,
        S_RESP
    } t_state;

endpackage

@@ rtl/core/ffha_if.sv @@
interface ffha_req_if;
    import ffha_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ffha_rsp_if;
    import ffha_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/first_fit_heap_allocator.sv @@
// First-fit heap allocator with coalescing.
// i_req carries one word per request: cmd 0 allocates request_bytes, cmd 1
// frees the block at block_offset (has_block 0 is a null free). o_rsp returns
// one word per request: status and, on a done allocate, the payload offset.
// The free table is held in one synchronous memory of start/length pairs,
// sorted by address; block lengths are held in a second memory per granule.
// Memory reads are registered, so the sequencer examines each table entry
// in the states S_SCAN_RD, S_SCAN_CHK and S_CHECK and moves each entry in
// S_SHIFT_RD and S_SHIFT_WR. An allocate scans up to the first fitting
// entry and moves entries when that entry is dropped; a free scans up to
// its insertion point and moves entries when it inserts an entry or merges
// with both neighbours. One request is handled at a time.
// After reset the table holds one entry covering the whole heap; no clearing
// pass is needed. A finished response is held in an output register until
// taken; the next request is accepted only while that register is empty or
// being read in the same cycle, so a stalled receiver holds off further
// requests as soon as one response is waiting.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES      = 65536,
    parameter int GRANULE_BYTES   = 16,
    parameter int HEADER_BYTES    = 32,
    parameter int MAX_FREE_BLOCKS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffha_req_if.sink   i_req,
    ffha_rsp_if.source o_rsp
);

    `include "assert_macros.svh"

    localparam int HEAP_GR = HEAP_BYTES / GRANULE_BYTES;
    localparam int GW      = $clog2(HEAP_GR + 1);
    localparam int GA      = $clog2(HEAP_GR);
    localparam int EW      = $clog2(MAX_FREE_BLOCKS + 1);
    localparam int EA      = $clog2(MAX_FREE_BLOCKS);
    localparam int GSH     = $clog2(GRANULE_BYTES);
    localparam int MIN_GR  = (HEADER_BYTES + 2 * GRANULE_BYTES - 1) / GRANULE_BYTES;
    localparam int XW      = GW + 2;

    // Free table and length store memories.
    logic [2*GW-1:0] r_ftab [MAX_FREE_BLOCKS];
    logic [GW-1:0]   r_lens [HEAP_GR];

    logic [2*GW-1:0] r_ft_q;
    logic [GW-1:0]   r_len_q;
    logic            ft_we, ft_re, len_we;
    logic [EA-1:0]   ft_wa, ft_ra;
    logic [2*GW-1:0] ft_wd;
    logic [GA-1:0]   len_a;
    logic [GW-1:0]   len_wd;

    always_ff @(posedge i_clk) begin
        if (ft_we) begin
            r_ftab[ft_wa] <= ft_wd;
        end
        if (ft_re) begin
            r_ft_q <= r_ftab[ft_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_lens[len_a] <= len_wd;
        end
        r_len_q <= r_lens[len_a];
    end

    // Control and working registers.
    t_state         r_state, n_state;
    logic [EW-1:0]  r_cnt, n_cnt;
    logic [EW-1:0]  r_idx, n_idx;
    logic [EW-1:0]  r_sh, n_sh;
    logic           r_init, n_init;
    logic           r_cmd, n_cmd;
    logic [XW-1:0]  r_need, n_need;
    logic [GW-1:0]  r_g, n_g;
    logic [GW-1:0]  r_len, n_len;
    logic [GW-1:0]  r_ps, n_ps;
    logic [GW-1:0]  r_pl, n_pl;
    logic [GW-1:0]  r_ns, n_ns;
    logic [GW-1:0]  r_nl, n_nl;
    logic           r_drop, n_drop;
    logic           r_ovld, n_ovld;
    t_rsp           r_rsp, n_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= EW'(1);
            r_init  <= 1'b1;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_init  <= n_init;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_sh <= n_sh; r_cmd <= n_cmd; r_need <= n_need;
        r_g <= n_g; r_len <= n_len; r_ps <= n_ps; r_pl <= n_pl;
        r_ns <= n_ns; r_nl <= n_nl; r_drop <= n_drop; r_rsp <= n_rsp;
    end

    // Table entry fields; entry 0 reads as the whole heap until first written.
    logic [GW-1:0] q_s, q_l;
    always_comb begin
        q_s = r_ft_q[2*GW-1:GW];
        q_l = r_ft_q[GW-1:0];
    end

    t_req          rq;
    logic [16:0]   rel;
    logic [XW-1:0] need_raw;
    logic [XW-1:0] g_end;
    logic [XW-1:0] p_end;

    assign rq       = i_req.data;
    assign i_req.ready = (r_state == S_IDLE) && !(r_ovld && !o_rsp.ready);
    assign o_rsp.valid = r_ovld;
    assign o_rsp.data  = r_rsp;
    assign rel      = {1'b0, rq.block_offset} - 17'(HEADER_BYTES);
    assign need_raw = XW'((32'(rq.request_bytes) + HEADER_BYTES + GRANULE_BYTES - 1) >> GSH);
    assign g_end    = XW'(r_g) + XW'(r_len);
    assign p_end    = XW'(r_ps) + XW'(r_pl);

    // Sequencer: next state, memory controls and response.
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_idx = r_idx; n_sh = r_sh;
        n_init = r_init; n_cmd = r_cmd; n_need = r_need; n_g = r_g;
        n_len = r_len; n_ps = r_ps; n_pl = r_pl; n_ns = r_ns; n_nl = r_nl;
        n_drop = r_drop; n_rsp = r_rsp;
        n_ovld = r_ovld && !o_rsp.ready;
        ft_we = 1'b0; ft_re = 1'b0; ft_wa = '0; ft_ra = '0; ft_wd = '0;
        len_we = 1'b0; len_a = r_g[GA-1:0]; len_wd = r_len;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_cmd = rq.cmd;
                    n_idx = '0;
                    n_rsp = '{status: ST_DONE, payload_offset: 16'd0};
                    if (rq.cmd == 1'(CMD_ALLOC)) begin
                        if (rq.request_bytes == 16'd0) begin
                            n_rsp.status = ST_IGNORED;
                            n_state = S_RESP;
                        end else begin
                            n_need = (need_raw < XW'(MIN_GR)) ? XW'(MIN_GR) : need_raw;
                            n_state = S_SCAN_RD;
                        end
                    end else begin
                        n_g = GW'(rel >> GSH);
                        if (!rq.has_block || rq.block_offset < 16'(HEADER_BYTES)
                            || rel[GSH-1:0] != '0
                            || 32'(rel >> GSH) >= HEAP_GR) begin
                            n_rsp.status = ST_IGNORED;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_LEN_RD;
                        end
                    end
                end
            end
            S_LEN_RD: begin
                n_state = S_LEN_CHK;
            end
            S_LEN_CHK: begin
                n_len = r_len_q;
                if (r_len_q == '0 || 32'(r_len_q) > HEAP_GR - 32'(r_g)) begin
                    n_rsp.status = ST_IGNORED;
                    n_state = S_RESP;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (r_idx >= r_cnt) begin
                    if (r_cmd == 1'(CMD_ALLOC)) begin
                        n_rsp.status = ST_NO_FIT;
                        n_state = S_RESP;
                    end else begin
                        n_ns = '0; n_nl = '0;
                        n_state = S_PREV_RD;
                    end
                end else begin
                    ft_re = 1'b1;
                    ft_ra = r_idx[EA-1:0];
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (r_init && r_idx == '0) begin
                    n_ns = '0; n_nl = GW'(HEAP_GR);
                end else begin
                    n_ns = q_s; n_nl = q_l;
                end
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_cmd == 1'(CMD_ALLOC)) begin
                    if (XW'(r_nl) >= r_need) begin
                        n_g = r_ns;
                        n_rsp.payload_offset =
                            16'((32'(r_ns) << GSH) + HEADER_BYTES);
                        if (XW'(r_nl) >= r_need + XW'(MIN_GR)) begin
                            n_len = GW'(r_need);
                            ft_we = 1'b1; ft_wa = r_idx[EA-1:0];
                            ft_wd = {GW'(XW'(r_ns) + r_need), GW'(XW'(r_nl) - r_need)};
                            n_init = 1'b0;
                            n_state = S_APPLY;
                            n_drop = 1'b0;
                        end else begin
                            n_len = r_nl;
                            n_drop = 1'b1;
                            n_sh = r_idx;
                            n_state = S_SHIFT_RD;
                        end
                    end else begin
                        n_idx = r_idx + EW'(1);
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    if (r_ns < r_g) begin
                        n_ps = r_ns; n_pl = r_nl;
                        n_idx = r_idx + EW'(1);
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_PREV_RD;
                    end
                end
            end
            // Check the freed block against its neighbours, then merge or insert.
            S_PREV_RD: begin
                n_state = S_PREV_CHK;
            end
            S_PREV_CHK: begin
                if (r_idx != '0 && p_end > XW'(r_g)) begin
                    n_rsp.status = ST_IGNORED; n_state = S_RESP;
                end else if (r_idx < r_cnt && g_end > XW'(r_ns)) begin
                    n_rsp.status = ST_IGNORED; n_state = S_RESP;
                end else begin
                    if (r_idx != '0 && p_end == XW'(r_g)) begin
                        if (r_idx < r_cnt && g_end == XW'(r_ns)) begin
                            ft_we = 1'b1; ft_wa = EA'(r_idx - EW'(1));
                            ft_wd = {r_ps, GW'(p_end + XW'(r_len) + XW'(r_nl) - XW'(r_ps))};
                            n_init = 1'b0;
                            n_drop = 1'b1; n_sh = r_idx;
                            n_state = S_SHIFT_RD;
                        end else begin
                            ft_we = 1'b1; ft_wa = EA'(r_idx - EW'(1));
                            ft_wd = {r_ps, r_pl + r_len};
                            n_init = 1'b0;
                            n_state = S_RESP;
                        end
                    end else if (r_idx < r_cnt && g_end == XW'(r_ns)) begin
                        ft_we = 1'b1; ft_wa = r_idx[EA-1:0];
                        ft_wd = {r_g, r_nl + r_len};
                        n_init = 1'b0;
                        n_state = S_RESP;
                    end else if (r_cnt >= EW'(MAX_FREE_BLOCKS)) begin
                        n_rsp.status = ST_FULL; n_state = S_RESP;
                    end else begin
                        n_drop = 1'b0; n_sh = r_cnt;
                        n_state = S_SHIFT_RD;
                    end
                end
            end
            // Move entries one place, reading each entry and then writing it.
            S_SHIFT_RD: begin
                if (r_drop) begin
                    if (r_sh + EW'(1) >= r_cnt) begin
                        n_cnt = r_cnt - EW'(1);
                        n_state = (r_cmd == 1'(CMD_ALLOC)) ? S_APPLY : S_RESP;
                    end else begin
                        ft_re = 1'b1; ft_ra = EA'(r_sh + EW'(1));
                        n_state = S_SHIFT_WR;
                    end
                end else begin
                    if (r_sh == r_idx) begin
                        ft_we = 1'b1; ft_wa = r_idx[EA-1:0];
                        ft_wd = {r_g, r_len};
                        n_init = 1'b0;
                        n_cnt = r_cnt + EW'(1);
                        n_state = S_RESP;
                    end else begin
                        ft_re = 1'b1; ft_ra = EA'(r_sh - EW'(1));
                        n_state = S_SHIFT_WR;
                    end
                end
            end
            S_SHIFT_WR: begin
                ft_we = 1'b1;
                ft_wd = (r_init && !r_drop && r_sh == EW'(1))
                        ? {GW'(0), GW'(HEAP_GR)} : r_ft_q;
                n_init = 1'b0;
                if (r_drop) begin
                    ft_wa = r_sh[EA-1:0];
                    n_sh = r_sh + EW'(1);
                end else begin
                    ft_wa = r_sh[EA-1:0];
                    n_sh = r_sh - EW'(1);
                end
                n_state = S_SHIFT_RD;
            end
            S_APPLY: begin
                len_we = 1'b1; len_a = r_g[GA-1:0]; len_wd = r_len;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_ovld || o_rsp.ready) begin
                    n_ovld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `ASSERT_CLK(a_cnt_range, i_clk, i_rst_n, r_cnt <= EW'(MAX_FREE_BLOCKS),
        "free table count out of range")
    `ASSERT_CLK(a_accept_idle, i_clk, i_rst_n,
        (i_req.valid && i_req.ready) |-> r_state == S_IDLE, "request taken while busy")
    `ASSERT_CLK(a_rsp_hold, i_clk, i_rst_n,
        (r_ovld && !o_rsp.ready) |=> r_ovld, "response dropped")
    `ASSERT_CLK(a_one_write, i_clk, i_rst_n, !(ft_we && r_state == S_IDLE),
        "table written while idle")

endmodule
